// File: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and codes for the slab block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GC    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Which list a slab sits on.
  typedef enum logic [1:0] {
    KIND_UNUSED  = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_PARTIAL = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_POP,
    ST_ALLOC_READ,
    ST_FREE_WALK,
    ST_FREE_PUSH,
    ST_GC_WALK
  } state_t;

  // Request payload.
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] free_slab;
    logic [7:0] free_block;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic        ok;
    logic [3:0]  got_slab;
    logic [7:0]  got_block;
    logic [12:0] active_blocks;
    logic [12:0] total_blocks;
  } rsp_t;

endpackage

// File: rtl/slab_block_allocator.sv
// ----------------------------------------------------------------------------
// slab_block_allocator
// Fixed-size block allocator over a pool of slabs with empty, partial and
// full lists and per-slab stacks of free block numbers.
// ----------------------------------------------------------------------------
// Usage: drive req and raise start; the request is taken at a clock edge
// where start is high and busy is low. Exactly one response follows, shown
// on rsp for one cycle with done high; it cannot be held off.
// cfg_we writes cfg_wdata into the blocks-per-slab register; write it only
// while no request is in flight. A new slab takes the value when brought in.
// Steps from the accepting edge to the done cycle:
//   alloc with a slab available: pop, then stack memory read.
//   alloc with nothing available, rejected free, unknown op: answered from idle.
//   free: walks its list until the predecessor is found, unless the slab is
//     at the head (at most MAX_SLABS entries), then pushes the block.
//   gc: clears each slab on the empty list in turn, then answers.
// The stack memory read is registered and the list walk follows one link
// per cycle. A new request can be accepted in the done cycle.
// Reset is synchronous; afterwards slab 0 is on the empty list with all its
// blocks free. No stack memory sweep is needed: a per-slab low-water mark
// tells which stack entries still hold their initial values.
// ----------------------------------------------------------------------------
module slab_block_allocator
  import sba_pkg::*;
#(
  parameter int MAX_SLABS  = 16,
  parameter int BLOCKS_MAX = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  localparam int SW  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int LW  = $clog2(MAX_SLABS + 1);
  localparam int BW  = (BLOCKS_MAX > 1) ? $clog2(BLOCKS_MAX) : 1;
  localparam int CW  = $clog2(BLOCKS_MAX + 1);
  localparam int TW  = $clog2(MAX_SLABS * BLOCKS_MAX + 1);
  localparam int STW = $clog2(MAX_SLABS + 1);
  localparam int AW  = SW + BW;
  localparam logic [LW-1:0]  NIL    = LW'(MAX_SLABS);
  localparam logic [STW-1:0] STEPS  = STW'(MAX_SLABS);
  localparam int             N0_INT = (BLOCKS_MAX < 256) ? BLOCKS_MAX : 256;
  localparam logic [CW-1:0]  N0     = CW'(N0_INT);

  // Configuration register.
  logic [8:0] blocks_in_slab;

  // Per-slab descriptors.
  logic [CW-1:0] slab_free_count [MAX_SLABS];
  logic [CW-1:0] slab_blocks     [MAX_SLABS];
  logic [CW-1:0] slab_low_water  [MAX_SLABS];
  kind_t         slab_kind       [MAX_SLABS];
  logic [LW-1:0] slab_link       [MAX_SLABS];

  // List heads and counters.
  logic [LW-1:0] partial_head;
  logic [LW-1:0] empty_head;
  logic [LW-1:0] full_head;
  logic [TW-1:0] active_count;
  logic [TW-1:0] total_count;

  // Sequencer registers.
  state_t        state;
  state_t        state_next;
  logic [LW-1:0] cur;
  kind_t         src;
  logic [STW-1:0] steps;
  logic [SW-1:0] fslab;
  logic [BW-1:0] fblock;
  logic [BW-1:0] pop_idx;
  logic          low_hit;
  logic          ok_r;
  logic [SW-1:0] gs_r;
  logic [BW-1:0] gb_r;

  // Stack memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [BW-1:0] mem_rdata;

  // Request decode.
  logic [CW-1:0] n_eff;
  logic [SW-1:0] unused_slab;
  logic          unused_found;
  logic [SW-1:0] req_slab;
  logic          free_valid;
  logic [LW-1:0] free_list_head;
  logic          free_at_head;
  logic          alloc_avail;

  // Current slab views.
  logic [SW-1:0] cs;
  logic          cur_nil;
  logic [CW-1:0] pop_cnt;
  logic [CW-1:0] pop_low;
  logic [CW-1:0] pop_c;
  kind_t         pop_tgt;
  logic [LW-1:0] pop_tgt_head;
  logic [CW-1:0] push_c;
  kind_t         push_tgt;

  assign busy = (state != ST_IDLE);

  // Effective blocks per slab, clamped into range.
  always_comb begin
    if (blocks_in_slab == 9'd0) begin
      n_eff = CW'(1);
    end else if (32'(blocks_in_slab) > BLOCKS_MAX) begin
      n_eff = CW'(BLOCKS_MAX);
    end else begin
      n_eff = CW'(blocks_in_slab);
    end
  end

  // Lowest-numbered unused slab.
  always_comb begin
    unused_slab  = '0;
    unused_found = 1'b0;
    for (int i = MAX_SLABS - 1; i >= 0; i--) begin
      if (slab_kind[i] == KIND_UNUSED) begin
        unused_slab  = SW'(i);
        unused_found = 1'b1;
      end
    end
  end

  // Free request checks.
  assign req_slab = SW'(req.free_slab);
  always_comb begin
    free_valid = 1'b0;
    if (32'(req.free_slab) < MAX_SLABS) begin
      free_valid = (slab_kind[req_slab] == KIND_PARTIAL ||
                    slab_kind[req_slab] == KIND_FULL) &&
                   (32'(req.free_block) < 32'(slab_blocks[req_slab])) &&
                   (slab_free_count[req_slab] < slab_blocks[req_slab]);
    end
  end
  assign free_list_head = (slab_kind[req_slab] == KIND_FULL) ? full_head : partial_head;
  assign free_at_head   = (free_list_head == LW'(req_slab));
  assign alloc_avail    = (partial_head != NIL) || (empty_head != NIL) || unused_found;

  // Views of the slab under the walker or being popped.
  assign cs      = SW'(cur);
  assign cur_nil = (cur >= NIL);
  assign pop_cnt = (src == KIND_UNUSED) ? n_eff : slab_free_count[cs];
  assign pop_low = (src == KIND_UNUSED) ? n_eff : slab_low_water[cs];
  assign pop_c   = pop_cnt - CW'(1);
  assign pop_tgt = (pop_c == '0) ? KIND_FULL : KIND_PARTIAL;
  always_comb begin
    if (pop_tgt == src) begin
      pop_tgt_head = slab_link[cs];
    end else if (pop_tgt == KIND_FULL) begin
      pop_tgt_head = full_head;
    end else begin
      pop_tgt_head = partial_head;
    end
  end
  assign push_c   = slab_free_count[fslab] + CW'(1);
  assign push_tgt = (push_c == slab_blocks[fslab]) ? KIND_EMPTY : KIND_PARTIAL;

  // Stack memory accesses: pop reads, free pushes.
  assign mem_raddr = {cs, BW'(pop_c)};
  assign mem_we    = (state == ST_FREE_PUSH);
  assign mem_waddr = {fslab, BW'(slab_free_count[fslab])};
  assign mem_wdata = fblock;

  sba_stack_mem #(
    .AW (AW),
    .DW (BW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (op_t'(req.op))
            OP_ALLOC: if (alloc_avail) state_next = ST_ALLOC_POP;
            OP_FREE: begin
              if (free_valid) state_next = free_at_head ? ST_FREE_PUSH : ST_FREE_WALK;
            end
            OP_GC:   state_next = ST_GC_WALK;
            OP_NONE: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC_POP:  state_next = ST_ALLOC_READ;
      ST_ALLOC_READ: state_next = ST_IDLE;
      ST_FREE_WALK: begin
        if (cur_nil || steps == STEPS || slab_link[cs] == LW'(fslab)) begin
          state_next = ST_FREE_PUSH;
        end
      end
      ST_FREE_PUSH:  state_next = ST_IDLE;
      ST_GC_WALK: begin
        if (cur_nil || steps == STEPS) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and descriptor updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_slab <= 9'd256;
      for (int i = 0; i < MAX_SLABS; i++) begin
        slab_free_count[i] <= '0;
        slab_blocks[i]     <= '0;
        slab_low_water[i]  <= '0;
        slab_kind[i]       <= KIND_UNUSED;
        slab_link[i]       <= NIL;
      end
      slab_free_count[0] <= N0;
      slab_blocks[0]     <= N0;
      slab_low_water[0]  <= N0;
      slab_kind[0]       <= KIND_EMPTY;
      partial_head       <= NIL;
      full_head          <= NIL;
      empty_head         <= LW'(0);
      active_count       <= '0;
      total_count        <= TW'(N0_INT);
      done               <= 1'b0;
      ok_r               <= 1'b0;
      gs_r               <= '0;
      gb_r               <= '0;
      cur                <= NIL;
      src                <= KIND_UNUSED;
      steps              <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        blocks_in_slab <= cfg_wdata;
      end
      unique case (state)
        // Take a request; trivial outcomes answer at once.
        ST_IDLE: begin
          if (start) begin
            fslab  <= req_slab;
            fblock <= BW'(req.free_block);
            steps  <= '0;
            gs_r   <= '0;
            gb_r   <= '0;
            ok_r   <= 1'b0;
            unique case (op_t'(req.op))
              OP_ALLOC: begin
                if (partial_head != NIL) begin
                  cur <= partial_head;
                  src <= KIND_PARTIAL;
                end else if (empty_head != NIL) begin
                  cur <= empty_head;
                  src <= KIND_EMPTY;
                end else if (unused_found) begin
                  cur <= LW'(unused_slab);
                  src <= KIND_UNUSED;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_FREE: begin
                if (!free_valid) begin
                  done <= 1'b1;
                end else if (free_at_head) begin
                  if (slab_kind[req_slab] == KIND_FULL) begin
                    full_head <= slab_link[req_slab];
                  end else begin
                    partial_head <= slab_link[req_slab];
                  end
                  slab_link[req_slab] <= NIL;
                end else begin
                  cur <= free_list_head;
                end
              end
              OP_GC: begin
                cur <= empty_head;
              end
              OP_NONE: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        // Pop the slab's top entry and relink it at the head of its new list.
        ST_ALLOC_POP: begin
          if (src == KIND_UNUSED) begin
            slab_blocks[cs] <= n_eff;
            total_count     <= total_count + TW'(n_eff);
          end
          slab_free_count[cs] <= pop_c;
          slab_low_water[cs]  <= (pop_c < pop_low) ? pop_c : pop_low;
          low_hit             <= (pop_c < pop_low);
          pop_idx             <= BW'(pop_c);
          active_count        <= active_count + TW'(1);
          slab_kind[cs]       <= pop_tgt;
          if (src == KIND_PARTIAL) begin
            partial_head <= slab_link[cs];
          end else if (src == KIND_EMPTY) begin
            empty_head <= slab_link[cs];
          end
          slab_link[cs] <= pop_tgt_head;
          if (pop_tgt == KIND_FULL) begin
            full_head <= cur;
          end else begin
            partial_head <= cur;
          end
          gs_r <= cs;
        end
        // Entries below the low-water mark were never overwritten.
        ST_ALLOC_READ: begin
          gb_r <= low_hit ? pop_idx : mem_rdata;
          ok_r <= 1'b1;
          done <= 1'b1;
        end
        // Walk the list one link a cycle to find the predecessor.
        ST_FREE_WALK: begin
          if (!cur_nil && steps != STEPS) begin
            if (slab_link[cs] == LW'(fslab)) begin
              slab_link[cs]    <= slab_link[fslab];
              slab_link[fslab] <= NIL;
            end else begin
              cur   <= slab_link[cs];
              steps <= steps + STW'(1);
            end
          end
        end
        // Push the block and put the slab at the head of its new list.
        ST_FREE_PUSH: begin
          slab_free_count[fslab] <= push_c;
          if (active_count != '0) begin
            active_count <= active_count - TW'(1);
          end
          slab_kind[fslab] <= push_tgt;
          if (push_tgt == KIND_EMPTY) begin
            slab_link[fslab] <= empty_head;
            empty_head       <= LW'(fslab);
          end else begin
            slab_link[fslab] <= partial_head;
            partial_head     <= LW'(fslab);
          end
          ok_r <= 1'b1;
          done <= 1'b1;
        end
        // Return every empty slab to the unused pool, one per cycle.
        ST_GC_WALK: begin
          if (cur_nil || steps == STEPS) begin
            empty_head <= NIL;
            ok_r       <= 1'b1;
            done       <= 1'b1;
          end else begin
            if (total_count >= TW'(slab_blocks[cs])) begin
              total_count <= total_count - TW'(slab_blocks[cs]);
            end else begin
              total_count <= '0;
            end
            slab_kind[cs]       <= KIND_UNUSED;
            slab_link[cs]       <= NIL;
            slab_free_count[cs] <= '0;
            slab_blocks[cs]     <= '0;
            cur                 <= slab_link[cs];
            steps               <= steps + STW'(1);
          end
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // Response payload.
  assign rsp.ok            = ok_r;
  assign rsp.got_slab      = 4'(gs_r);
  assign rsp.got_block     = 8'(gb_r);
  assign rsp.active_blocks = 13'(active_count);
  assign rsp.total_blocks  = 13'(total_count);

endmodule

// File: rtl/sba_stack_mem.sv
// ----------------------------------------------------------------------------
// sba_stack_mem
// Block number stacks of all slabs: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sba_stack_mem #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sba_checker.sv
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks of the slab block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker
  import sba_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input rsp_t       rsp,
  input logic       cfg_we
);

  // A response is only shown once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // An accepted request either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither busy nor answered");

  // Responses never appear without an earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("response without request");

  // A failed request carries no block handle.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.ok |-> rsp.got_slab == 4'd0 && rsp.got_block == 8'd0)
    else $error("failed response carries a handle");

  // The register is only written while no request is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !busy)
    else $error("register written while busy");

endmodule

bind slab_block_allocator sba_checker u_sba_checker (.*);

// File: bench/sba_checker.sv
// ----------------------------------------------------------------------------
// sba_monitor
// Watches the request, response and register ports of the slab allocator.
// It keeps its own model of the slab lists and block stacks and checks
// each response against the oldest predicted one.
// ----------------------------------------------------------------------------
module sba_monitor
  import sba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  req_t       req,
  input  logic       done,
  input  rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLAB = 16;
  localparam int NBLK  = 256;
  localparam int NIL   = NSLAB;

  // Shadow allocator state.
  logic [7:0] blk_stack [NSLAB][NBLK];
  int         free_cnt [NSLAB];
  int         blk_count [NSLAB];
  kind_t      slab_kind [NSLAB];
  int         next_slab [NSLAB];
  int         list_head [4];
  int         active_cnt;
  int         total_cnt;
  logic [8:0] per_slab_reg;
  rsp_t       rsp_q [$];

  function automatic int clamp_size();
    if (per_slab_reg == 0) return 1;
    if (per_slab_reg > NBLK) return NBLK;
    return per_slab_reg;
  endfunction

  // Load a fresh slab: block n-1 sits on top of the stack.
  task automatic load_slab(int s);
    int n;
    n = clamp_size();
    for (int i = 0; i < n; i++) blk_stack[s][i] = i[7:0];
    blk_count[s] = n;
    free_cnt[s] = n;
  endtask

  task automatic put_on_list(kind_t k, int s);
    next_slab[s] = list_head[k];
    list_head[k] = s;
    slab_kind[s] = k;
  endtask

  // Remove a slab from anywhere in its list.
  task automatic take_off_list(kind_t k, int s);
    int cur;
    if (list_head[k] == s) begin
      list_head[k] = next_slab[s];
      next_slab[s] = NIL;
      return;
    end
    cur = list_head[k];
    for (int i = 0; i < NSLAB && cur < NSLAB; i++) begin
      if (next_slab[cur] == s) begin
        next_slab[cur] = next_slab[s];
        next_slab[s] = NIL;
        return;
      end
      cur = next_slab[cur];
    end
  endtask

  task automatic clear_allocator();
    for (int s = 0; s < NSLAB; s++) begin
      free_cnt[s] = 0;
      blk_count[s] = 0;
      slab_kind[s] = KIND_UNUSED;
      next_slab[s] = NIL;
    end
    for (int k = 0; k < 4; k++) list_head[k] = NIL;
    per_slab_reg = 9'd256;
    active_cnt = 0;
    load_slab(0);
    put_on_list(KIND_EMPTY, 0);
    total_cnt = blk_count[0];
  endtask

  // Apply one request to the shadow state and build its response.
  task automatic apply_request(input req_t r, output rsp_t e);
    int s, c, fs, nx;
    e = '0;
    s = NIL;
    fs = r.free_slab;
    case (op_t'(r.op))
      OP_ALLOC: begin
        if (list_head[KIND_PARTIAL] < NSLAB) begin
          s = list_head[KIND_PARTIAL];
          take_off_list(KIND_PARTIAL, s);
        end else if (list_head[KIND_EMPTY] < NSLAB) begin
          s = list_head[KIND_EMPTY];
          take_off_list(KIND_EMPTY, s);
        end else begin
          for (int i = 0; i < NSLAB; i++) begin
            if (s == NIL && slab_kind[i] == KIND_UNUSED) s = i;
          end
          if (s < NSLAB) begin
            load_slab(s);
            total_cnt += blk_count[s];
          end
        end
        if (s < NSLAB && free_cnt[s] > 0) begin
          c = free_cnt[s] - 1;
          free_cnt[s] = c;
          e.ok = 1'b1;
          e.got_slab = s[3:0];
          e.got_block = blk_stack[s][c];
          active_cnt++;
          if (c == 0) put_on_list(KIND_FULL, s);
          else put_on_list(KIND_PARTIAL, s);
        end
      end
      OP_FREE: begin
        if ((slab_kind[fs] == KIND_PARTIAL || slab_kind[fs] == KIND_FULL) &&
            int'(r.free_block) < blk_count[fs] && free_cnt[fs] < blk_count[fs]) begin
          c = free_cnt[fs];
          take_off_list(slab_kind[fs], fs);
          blk_stack[fs][c] = r.free_block;
          c++;
          free_cnt[fs] = c;
          if (active_cnt > 0) active_cnt--;
          e.ok = 1'b1;
          if (c == blk_count[fs]) put_on_list(KIND_EMPTY, fs);
          else put_on_list(KIND_PARTIAL, fs);
        end
      end
      OP_GC: begin
        s = list_head[KIND_EMPTY];
        for (int i = 0; i < NSLAB && s < NSLAB; i++) begin
          nx = next_slab[s];
          total_cnt = (total_cnt >= blk_count[s]) ? total_cnt - blk_count[s] : 0;
          slab_kind[s] = KIND_UNUSED;
          next_slab[s] = NIL;
          free_cnt[s] = 0;
          blk_count[s] = 0;
          s = nx;
        end
        list_head[KIND_EMPTY] = NIL;
        e.ok = 1'b1;
      end
      default: ;
    endcase
    e.active_blocks = active_cnt[12:0];
    e.total_blocks = total_cnt[12:0];
  endtask

  // Compare responses first, then predict the request taken at this edge.
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      clear_allocator();
      rsp_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) per_slab_reg = cfg_wdata;
      if (done) begin
        if (rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          errors <= errors + 1;
        end else begin
          e = rsp_q.pop_front();
          if (rsp !== e) begin
            if (rsp.ok !== e.ok)
              $error("ok: expected %0d, got %0d", e.ok, rsp.ok);
            if (rsp.got_slab !== e.got_slab)
              $error("got_slab: expected %0d, got %0d", e.got_slab, rsp.got_slab);
            if (rsp.got_block !== e.got_block)
              $error("got_block: expected %0d, got %0d", e.got_block, rsp.got_block);
            if (rsp.active_blocks !== e.active_blocks)
              $error("active_blocks: expected %0d, got %0d",
                     e.active_blocks, rsp.active_blocks);
            if (rsp.total_blocks !== e.total_blocks)
              $error("total_blocks: expected %0d, got %0d",
                     e.total_blocks, rsp.total_blocks);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        apply_request(req, e);
        rsp_q.push_back(e);
      end
    end
    pending <= rsp_q.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the slab block allocator: directed list and exhaustion cases,
// then mostly alloc/free traffic over several blocks-per-slab settings,
// with random gaps. The checker module does all response checking.
// ----------------------------------------------------------------------------
module tb;
  import sba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0] slab;
    logic [7:0] blk;
  } handle_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         errors;
  int         pending;

  handle_t    live_q [$];
  op_t        issued_q [$];
  int         n_req [4];
  int         n_grant;
  int         n_denied;

  slab_block_allocator u_top (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_wdata
  );

  sba_monitor u_chk (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_wdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Track handed-out blocks so frees can target them.
  always @(posedge clk) begin
    op_t o;
    if (!rst) begin
      if (start && !busy) begin
        issued_q.push_back(op_t'(req.op));
        n_req[req.op]++;
      end
      if (done && issued_q.size() > 0) begin
        o = issued_q.pop_front();
        if (o == OP_ALLOC) begin
          if (rsp.ok) begin
            live_q.push_back('{rsp.got_slab, rsp.got_block});
            n_grant++;
          end else n_denied++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Issue one request and hold it until the allocator takes it.
  task automatic send(op_t op, logic [3:0] s, logic [7:0] b, int gap);
    start <= 1'b1;
    req <= '{op: op, free_slab: s, free_block: b};
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(logic [8:0] v);
    quiesce();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live(bit keep, int gap);
    int i;
    handle_t h;
    if (live_q.size() == 0) begin
      send(OP_FREE, 4'($urandom), 8'($urandom), gap);
      return;
    end
    i = $urandom_range(live_q.size() - 1);
    h = live_q[i];
    if (!keep) live_q.delete(i);
    send(OP_FREE, h.slab, h.blk, gap);
  endtask

  // Mostly well-formed alloc/free traffic with some noise.
  task automatic random_phase(int count, int alloc_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < alloc_pct) send(OP_ALLOC, 4'($urandom), 8'($urandom), pick_gap());
      else if (r < 85) free_live(1'b0, pick_gap());
      else if (r < 90) send(OP_FREE, 4'($urandom), 8'($urandom), pick_gap());
      else if (r < 94) send(OP_GC, 4'($urandom), 8'($urandom), pick_gap());
      else if (r < 97) free_live(1'b1, pick_gap());
      else send(OP_NONE, 4'($urandom), 8'($urandom), pick_gap());
      if (n == count / 2) quiesce();
    end
  endtask

  initial begin
    handle_t h;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    n_grant = 0;
    n_denied = 0;
    for (int k = 0; k < 4; k++) n_req[k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset slab, unused slab free, op 3, gc.
    send(OP_ALLOC, 4'd0, 8'd0, 0);
    send(OP_ALLOC, 4'd0, 8'd0, 1);
    send(OP_FREE, 4'd15, 8'd255, 0);
    send(OP_NONE, 4'd0, 8'd0, 0);
    send(OP_GC, 4'd0, 8'd0, 0);
    quiesce();
    while (live_q.size() > 0) free_live(1'b0, 0);
    send(OP_GC, 4'd0, 8'd0, 0);

    // One block per slab: fill the pool, exhaust it, free from mid-list.
    set_size(9'd1);
    repeat (17) send(OP_ALLOC, 4'd0, 8'd0, 0);
    quiesce();
    send(OP_FREE, 4'd7, 8'd1, 0);
    send(OP_FREE, 4'd7, 8'd0, 0);
    send(OP_FREE, 4'd7, 8'd0, 0);
    send(OP_FREE, 4'd3, 8'd0, 0);
    send(OP_GC, 4'd0, 8'd0, 0);
    quiesce();

    // Double free on a partial slab.
    set_size(9'd4);
    send(OP_ALLOC, 4'd0, 8'd0, 0);
    quiesce();
    h = live_q[live_q.size() - 1];
    send(OP_FREE, h.slab, 8'd0, 0);
    send(OP_FREE, h.slab, 8'd3, 0);

    // Random phases over several register values, extremes included.
    live_q.delete();
    set_size(9'd0);
    random_phase(90, 60);
    set_size(9'd256);
    random_phase(120, 55);
    set_size(9'd511);
    random_phase(90, 55);
    set_size(9'd300);
    random_phase(80, 55);
    set_size(9'd1);
    random_phase(100, 50);
    set_size(9'd2);
    random_phase(100, 60);
    set_size(9'($urandom_range(20, 3)));
    random_phase(120, 55);
    set_size(9'($urandom));
    random_phase(100, 55);
    set_size(9'd8);
    random_phase(100, 70);

    quiesce();
    $display("Covered %0d allocs (%0d granted, %0d denied), %0d frees, %0d gc, %0d no-op",
             n_req[OP_ALLOC], n_grant, n_denied, n_req[OP_FREE], n_req[OP_GC],
             n_req[OP_NONE]);
    $display("over block-per-slab settings 0, 1, 2, 4, 8, 256, 300, 511 and random.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
